### rtl/core/nsfm_pkg.sv
`timescale 1ns / 1ps

package nsfm_pkg;

  // geometry
  localparam int WINDOW_COUNT = 8;
  localparam int WIN_W        = $clog2(WINDOW_COUNT);
  localparam int BANK_BITS    = 8;
  localparam int OFFS_W       = 12;
  localparam int ROM_OFFS_W   = 20;
  localparam int CNT_W        = 10;
  localparam int STEP_W       = $clog2(BANK_BITS);
  localparam int MASK_W       = 7;
  localparam int ADDR_W       = 16;
  localparam int OP_W         = 2;
  localparam int STAT_W       = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PRG_W      = 21;
  localparam int SOUND_W    = 6;

  // rom size in whole 4 KiB banks
  localparam int LAST_W     = PRG_W - OFFS_W;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // last window and last divide step
  localparam logic [WIN_W-1:0]  WIN_LAST  = WIN_W'(WINDOW_COUNT - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BANK_BITS - 1);

  // op codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_LOAD = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRG_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_ADDR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NSF_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WORDS = 3'd4;

  // sound chip enable bits
  localparam int EN_VRC6 = 0;
  localparam int EN_VRC7 = 1;
  localparam int EN_FDS  = 2;
  localparam int EN_MMC5 = 3;
  localparam int EN_N163 = 4;
  localparam int EN_FME7 = 5;

  // forward mask bits
  localparam int FW_N163_LO = 0;
  localparam int FW_MMC5    = 1;
  localparam int FW_FDS     = 2;
  localparam int FW_VRC6    = 3;
  localparam int FW_VRC7    = 4;
  localparam int FW_N163_HI = 5;
  localparam int FW_FME7    = 6;

  // address map
  localparam logic [ADDR_W-1:0] ADDR_LOW_PORT = 16'h4020;
  localparam logic [ADDR_W-1:0] ADDR_N163_LO  = 16'h4800;
  localparam logic [ADDR_W-1:0] ADDR_MMC5     = 16'h5000;
  localparam logic [ADDR_W-1:0] ADDR_MMC5_END = 16'h5FF5;
  localparam logic [ADDR_W-1:0] ADDR_BANK_SEL = 16'h5FF8;
  localparam logic [ADDR_W-1:0] ADDR_LOW_END  = 16'h5FFF;
  localparam logic [ADDR_W-1:0] ADDR_VRC6_A   = 16'h9000;
  localparam logic [ADDR_W-1:0] ADDR_VRC6_A_E = 16'h9003;
  localparam logic [ADDR_W-1:0] ADDR_VRC6_B   = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_VRC6_B_E = 16'hA002;
  localparam logic [ADDR_W-1:0] ADDR_VRC6_C   = 16'hB000;
  localparam logic [ADDR_W-1:0] ADDR_VRC6_C_E = 16'hB002;
  localparam logic [ADDR_W-1:0] ADDR_VRC7_A   = 16'h9010;
  localparam logic [ADDR_W-1:0] ADDR_VRC7_D   = 16'h9030;
  localparam logic [ADDR_W-1:0] ADDR_N163_HI  = 16'hF800;
  localparam logic [ADDR_W-1:0] ADDR_FME7_A   = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_FME7_D   = 16'hE000;
  localparam logic [OFFS_W-1:0] WINDOW_MASK   = 12'hFFF;

  typedef struct packed {
    logic [PRG_W-1:0]      prg_rom_size;
    logic [ADDR_W-1:0]     load_address;
    logic [SOUND_W-1:0]    extra_sound_mask;
    logic                  nsf_mode;
    logic [CFG_DATA_W-1:0] bank_init_words;
  } cfg_t;

  typedef enum logic [2:0] {
    CMD_REPORT,
    CMD_BANK_WR,
    CMD_READ,
    CMD_INIT_BYTES,
    CMD_INIT_LINEAR,
    CMD_INIT_PLAIN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [MASK_W-1:0]    fwd_mask;
    logic [STAT_W-1:0]    status;
    logic [WIN_W-1:0]     window;
    logic [BANK_BITS-1:0] data;
    logic [OFFS_W-1:0]    offs_low;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_DIV
  } back_state_t;

endpackage

### rtl/core/nsfm_in_if.sv
`timescale 1ns / 1ps

interface nsfm_in_if;
  logic                         valid;
  logic                         ready;
  logic [nsfm_pkg::OP_W-1:0]    op;
  logic [nsfm_pkg::ADDR_W-1:0]  cpu_address;
  logic [nsfm_pkg::BANK_BITS-1:0] write_data;

  modport source (output valid, output op, output cpu_address, output write_data,
                  input ready);
  modport sink   (input valid, input op, input cpu_address, input write_data,
                  output ready);
endinterface

### rtl/core/nsfm_out_if.sv
`timescale 1ns / 1ps

interface nsfm_out_if;
  logic                             valid;
  logic                             ready;
  logic [nsfm_pkg::MASK_W-1:0]      forward_mask;
  logic                             bank_written;
  logic [nsfm_pkg::WIN_W-1:0]       bank_window;
  logic [nsfm_pkg::BANK_BITS-1:0]   bank_value;
  logic [nsfm_pkg::ROM_OFFS_W-1:0]  rom_offset;
  logic [nsfm_pkg::STAT_W-1:0]      status;

  modport source (output valid, output forward_mask, output bank_written,
                  output bank_window, output bank_value, output rom_offset,
                  output status, input ready);
  modport sink   (input valid, input forward_mask, input bank_written,
                  input bank_window, input bank_value, input rom_offset,
                  input status, output ready);
endinterface

### rtl/core/nsfm_front.sv
`timescale 1ns / 1ps

module nsfm_front (
  nsfm_in_if.sink           in_ch,
  input  nsfm_pkg::cfg_t    cfg,
  output logic              push_valid,
  input  logic              push_ready,
  output nsfm_pkg::cmd_t    push_cmd
);
  import nsfm_pkg::*;

  logic [ADDR_W-1:0]  a;
  logic [SOUND_W-1:0] ex;
  logic               mmc5_hit;
  logic               blocked;
  cmd_t               cmd;

  // handshake passes straight through to the queue
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;
  assign push_cmd    = cmd;

  assign a  = in_ch.cpu_address;
  assign ex = cfg.extra_sound_mask;

  // low port mmc5 decode
  assign mmc5_hit = ex[EN_MMC5] && (a >= ADDR_MMC5);
  assign blocked  = mmc5_hit && (a <= ADDR_MMC5_END);

  // classify the beat into a command for the back end
  always_comb begin
    cmd        = '0;
    cmd.kind   = CMD_REPORT;
    cmd.status = STAT_OK;
    case (in_ch.op)
      OP_WRITE: begin
        if (a >= ADDR_LOW_PORT && a <= ADDR_LOW_END) begin
          if (ex[EN_N163] && a == ADDR_N163_LO) begin
            cmd.fwd_mask[FW_N163_LO] = 1'b1;
          end
          if (mmc5_hit) begin
            cmd.fwd_mask[FW_MMC5] = 1'b1;
          end
          if (!blocked) begin
            if (a >= ADDR_MMC5) begin
              if (a >= ADDR_BANK_SEL) begin
                cmd.kind   = CMD_BANK_WR;
                cmd.window = a[WIN_W-1:0];
                cmd.data   = in_ch.write_data;
              end
            end else if (ex[EN_FDS]) begin
              cmd.fwd_mask[FW_FDS] = 1'b1;
            end
          end
        end else if (a[ADDR_W-1]) begin
          if (ex[EN_VRC6] &&
              ((a >= ADDR_VRC6_A && a <= ADDR_VRC6_A_E) ||
               (a >= ADDR_VRC6_B && a <= ADDR_VRC6_B_E) ||
               (a >= ADDR_VRC6_C && a <= ADDR_VRC6_C_E))) begin
            cmd.fwd_mask[FW_VRC6] = 1'b1;
          end
          if (ex[EN_VRC7] && (a == ADDR_VRC7_A || a == ADDR_VRC7_D)) begin
            cmd.fwd_mask[FW_VRC7] = 1'b1;
          end
          if (ex[EN_N163] && a == ADDR_N163_HI) begin
            cmd.fwd_mask[FW_N163_HI] = 1'b1;
          end
          if (ex[EN_FME7] && (a == ADDR_FME7_A || a == ADDR_FME7_D)) begin
            cmd.fwd_mask[FW_FME7] = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (a[ADDR_W-1]) begin
          cmd.kind     = CMD_READ;
          cmd.window   = a[OFFS_W +: WIN_W];
          cmd.offs_low = a[OFFS_W-1:0] & WINDOW_MASK;
        end else begin
          cmd.status = STAT_OUTSIDE;
        end
      end
      OP_INIT: begin
        if (cfg.nsf_mode) begin
          // load address below $8000 is not supported
          if (!cfg.load_address[ADDR_W-1]) begin
            cmd.status = STAT_BAD_LOAD;
          end else begin
            cmd.kind   = (cfg.bank_init_words != '0) ? CMD_INIT_BYTES : CMD_INIT_LINEAR;
            cmd.window = cfg.load_address[OFFS_W +: WIN_W];
          end
        end else begin
          cmd.kind = CMD_INIT_PLAIN;
        end
      end
      default: begin
        cmd.kind = CMD_REPORT;
      end
    endcase
  end

endmodule

### rtl/core/nsfm_queue.sv
`timescale 1ns / 1ps

module nsfm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  nsfm_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output nsfm_pkg::cmd_t pop_cmd
);
  import nsfm_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    if (push_fire && !pop_fire) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (pop_fire && !push_fire) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/core/nsfm_back.sv
`timescale 1ns / 1ps

module nsfm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nsfm_pkg::cfg_t                cfg,
  input  logic [nsfm_pkg::CNT_W-1:0]    bank_count,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  nsfm_pkg::cmd_t                pop_cmd,
  nsfm_out_if.source                    out_ch
);
  import nsfm_pkg::*;

  back_state_t          state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [WIN_W-1:0]     win_r, win_nxt;
  logic [BANK_BITS-1:0] dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [BANK_BITS-1:0] bank_r [WINDOW_COUNT];
  logic [BANK_BITS-1:0] bank_nxt [WINDOW_COUNT];

  logic                  out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]     out_mask_r, out_mask_nxt;
  logic                  out_wr_r, out_wr_nxt;
  logic [WIN_W-1:0]      out_win_r, out_win_nxt;
  logic [BANK_BITS-1:0]  out_val_r, out_val_nxt;
  logic [ROM_OFFS_W-1:0] out_offs_r, out_offs_nxt;
  logic [STAT_W-1:0]     out_stat_r, out_stat_nxt;

  logic                  pop_fire;
  logic                  div_last;
  logic [CNT_W:0]        shifted;
  logic                  ge;
  logic [CNT_W-1:0]      rem_step;
  logic [BANK_BITS-1:0]  mod_result;
  logic [LAST_W-1:0]     last_bank;
  logic [BANK_BITS-1:0]  plain_bank;
  logic [WIN_W-1:0]      win_inc;

  assign pop_ready = (state_r == BK_IDLE) && (!out_valid_r || out_ch.ready);
  assign pop_fire  = pop_valid && pop_ready;
  assign div_last  = (step_r == STEP_LAST);
  assign win_inc   = WIN_W'(win_r + 1'b1);

  // one restoring step of data mod bank count
  assign shifted    = {rem_r, dvd_r[BANK_BITS-1]};
  assign ge         = (shifted >= {1'b0, bank_count});
  assign rem_step   = ge ? CNT_W'(shifted - {1'b0, bank_count}) : CNT_W'(shifted);
  assign mod_result = (bank_count == '0) ? '0 : rem_step[BANK_BITS-1:0];

  // plain cartridge: last 4 KiB bank into the top window
  assign last_bank  = cfg.prg_rom_size[PRG_W-1:OFFS_W];
  assign plain_bank = (last_bank == '0) ? '0 : BANK_BITS'(last_bank - 1'b1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop_fire && (pop_cmd.kind == CMD_BANK_WR || pop_cmd.kind == CMD_INIT_BYTES)) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_last && (cmd_r.kind == CMD_BANK_WR || win_r == WIN_LAST)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // datapath, bank registers and result register
  always_comb begin
    cmd_nxt       = cmd_r;
    win_nxt       = win_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    bank_nxt      = bank_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    out_mask_nxt  = out_mask_r;
    out_wr_nxt    = out_wr_r;
    out_win_nxt   = out_win_r;
    out_val_nxt   = out_val_r;
    out_offs_nxt  = out_offs_r;
    out_stat_nxt  = out_stat_r;
    case (state_r)
      BK_IDLE: begin
        if (pop_fire) begin
          cmd_nxt  = pop_cmd;
          win_nxt  = pop_cmd.window;
          rem_nxt  = '0;
          step_nxt = '0;
          dvd_nxt  = (pop_cmd.kind == CMD_INIT_BYTES) ?
                     cfg.bank_init_words[{pop_cmd.window, 3'b000} +: BANK_BITS] :
                     pop_cmd.data;
          case (pop_cmd.kind)
            CMD_REPORT: begin
              out_valid_nxt = 1'b1;
              out_mask_nxt  = pop_cmd.fwd_mask;
              out_wr_nxt    = 1'b0;
              out_win_nxt   = '0;
              out_val_nxt   = '0;
              out_offs_nxt  = '0;
              out_stat_nxt  = pop_cmd.status;
            end
            CMD_READ: begin
              out_valid_nxt = 1'b1;
              out_mask_nxt  = '0;
              out_wr_nxt    = 1'b0;
              out_win_nxt   = '0;
              out_val_nxt   = '0;
              out_offs_nxt  = {bank_r[pop_cmd.window], pop_cmd.offs_low};
              out_stat_nxt  = STAT_OK;
            end
            CMD_INIT_LINEAR: begin
              // windows from the start one count up while below the bank count
              for (int w = 0; w < WINDOW_COUNT; w++) begin
                if (WIN_W'(w) >= pop_cmd.window &&
                    CNT_W'(WIN_W'(WIN_W'(w) - pop_cmd.window)) < bank_count) begin
                  bank_nxt[w] = BANK_BITS'(WIN_W'(WIN_W'(w) - pop_cmd.window));
                end
              end
              out_valid_nxt = 1'b1;
              out_mask_nxt  = '0;
              out_wr_nxt    = 1'b0;
              out_win_nxt   = '0;
              out_val_nxt   = '0;
              out_offs_nxt  = '0;
              out_stat_nxt  = STAT_OK;
            end
            CMD_INIT_PLAIN: begin
              bank_nxt[WIN_LAST] = plain_bank;
              out_valid_nxt = 1'b1;
              out_mask_nxt  = '0;
              out_wr_nxt    = 1'b0;
              out_win_nxt   = '0;
              out_val_nxt   = '0;
              out_offs_nxt  = '0;
              out_stat_nxt  = STAT_OK;
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      BK_DIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = {dvd_r[BANK_BITS-2:0], 1'b0};
        step_nxt = STEP_W'(step_r + 1'b1);
        if (div_last) begin
          bank_nxt[win_r] = mod_result;
          if (cmd_r.kind == CMD_BANK_WR) begin
            out_valid_nxt = 1'b1;
            out_mask_nxt  = cmd_r.fwd_mask;
            out_wr_nxt    = 1'b1;
            out_win_nxt   = win_r;
            out_val_nxt   = mod_result;
            out_offs_nxt  = '0;
            out_stat_nxt  = STAT_OK;
          end else if (win_r == WIN_LAST) begin
            out_valid_nxt = 1'b1;
            out_mask_nxt  = '0;
            out_wr_nxt    = 1'b0;
            out_win_nxt   = '0;
            out_val_nxt   = '0;
            out_offs_nxt  = '0;
            out_stat_nxt  = STAT_OK;
          end else begin
            // move on to the next init byte
            win_nxt  = win_inc;
            dvd_nxt  = cfg.bank_init_words[{win_inc, 3'b000} +: BANK_BITS];
            rem_nxt  = '0;
            step_nxt = '0;
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      for (int w = 0; w < WINDOW_COUNT; w++) begin
        bank_r[w] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bank_r      <= bank_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    win_r      <= win_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    out_mask_r <= out_mask_nxt;
    out_wr_r   <= out_wr_nxt;
    out_win_r  <= out_win_nxt;
    out_val_r  <= out_val_nxt;
    out_offs_r <= out_offs_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.forward_mask = out_mask_r;
  assign out_ch.bank_written = out_wr_r;
  assign out_ch.bank_window  = out_win_r;
  assign out_ch.bank_value   = out_val_r;
  assign out_ch.rom_offset   = out_offs_r;
  assign out_ch.status       = out_stat_r;

endmodule

### rtl/core/nsf_bank_switch_mapper.sv
`timescale 1ns / 1ps
// Bank-switch mapper for an NSF player, CPU space $8000-$FFFF in eight 4 KiB windows.
// in_ch carries one CPU beat (op, cpu_address, write_data): a write, a ROM read to
// translate, or a song init. out_ch returns exactly one result beat per input beat,
// in order. cfg_wr_en / cfg_index / cfg_wdata write the five setup registers; write
// them only while no beat is in flight.
// Inputs are classified combinationally and parked in a two-entry command queue; the
// back end pulls one command at a time and owns the bank registers and result reg.
// Reads, routing-only writes, linear and plain init take a queue entry and then the
// result register. A bank select write passes through the bit-per-cycle modulo unit
// before its result is registered; init from init bytes runs the unit once per window,
// from the load window up to the top window, and reports one result at the end.
// Simple commands flow at one beat per cycle while results are taken; the shared
// modulo unit keeps the back end busy for bank writes and byte init until it ends.
// If the receiver stalls, the result holds in its register, the queue fills and
// in_ch.ready drops once both entries are taken.
// Synchronous reset restores the register defaults (4 KiB ROM, load at $8000,
// player mode) and clears all bank registers to zero.
module nsf_bank_switch_mapper (
  input  logic                            clk,
  input  logic                            rst_n,
  nsfm_in_if.sink                         in_ch,
  nsfm_out_if.source                      out_ch,
  input  logic                            cfg_wr_en,
  input  logic [nsfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsfm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import nsfm_pkg::*;

  cfg_t             cfg_r, cfg_nxt;
  logic [CNT_W-1:0] bank_count_r, bank_count_nxt;
  logic [PRG_W:0]   count_sum;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_PRG_SIZE:   cfg_nxt.prg_rom_size     = cfg_wdata[PRG_W-1:0];
        REG_LOAD_ADDR:  cfg_nxt.load_address     = cfg_wdata[ADDR_W-1:0];
        REG_SOUND_MASK: cfg_nxt.extra_sound_mask = cfg_wdata[SOUND_W-1:0];
        REG_NSF_MODE:   cfg_nxt.nsf_mode         = cfg_wdata[0];
        REG_INIT_WORDS: cfg_nxt.bank_init_words  = cfg_wdata;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  // bank count = ceil((rom size + load offset) / 4 KiB)
  assign count_sum = {1'b0, cfg_r.prg_rom_size}
                   + (PRG_W + 1)'(cfg_r.load_address[OFFS_W-1:0])
                   + (PRG_W + 1)'(WINDOW_MASK);
  assign bank_count_nxt = count_sum[PRG_W:OFFS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prg_rom_size     <= PRG_W'(4096);
      cfg_r.load_address     <= 16'h8000;
      cfg_r.extra_sound_mask <= '0;
      cfg_r.nsf_mode         <= 1'b1;
      cfg_r.bank_init_words  <= '0;
      bank_count_r           <= CNT_W'(1);
    end else begin
      cfg_r        <= cfg_nxt;
      bank_count_r <= bank_count_nxt;
    end
  end

  nsfm_front u_front (
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  nsfm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  nsfm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .bank_count (bank_count_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  // a bank write result is never also an error or a translated read
  a_bank_wr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bank_written |-> out_ch.status == STAT_OK && out_ch.rom_offset == '0)
    else $error("bank write result carries status or offset");

  // an error status reports nothing else
  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != STAT_OK |->
      out_ch.forward_mask == '0 && !out_ch.bank_written && out_ch.rom_offset == '0)
    else $error("error result carries other fields");

  // the back end never takes a command while a result is stuck
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !(pop_valid && pop_ready))
    else $error("command popped while result stalled");

  // a translated offset only comes from a plain read
  a_offs_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.rom_offset != '0 |-> out_ch.forward_mask == '0 && !out_ch.bank_written)
    else $error("rom offset on a non-read result");
`endif

endmodule

### tb/sv/nsfm_checker.sv
`timescale 1ns / 1ps

module nsfm_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  nsfm_in_if                              in_ch,
  nsfm_out_if                             out_ch,
  input  logic                            cfg_wr_en,
  input  logic [nsfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsfm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              pending,
  output int                              fail_count
);
  import nsfm_pkg::*;

  localparam logic [PRG_W-1:0]  RESET_PRG_SIZE  = 21'd4096;
  localparam logic [ADDR_W-1:0] RESET_LOAD_ADDR = 16'h8000;
  localparam int                PRINT_LIMIT     = 60;

  typedef struct packed {
    logic [MASK_W-1:0]     forward_mask;
    logic                  bank_written;
    logic [WIN_W-1:0]      bank_window;
    logic [BANK_BITS-1:0]  bank_value;
    logic [ROM_OFFS_W-1:0] rom_offset;
    logic [STAT_W-1:0]     status;
  } map_result_t;

  // mirror of the mapper registers
  logic [PRG_W-1:0]      prg_size;
  logic [ADDR_W-1:0]     tune_base;
  logic [SOUND_W-1:0]    sound_en;
  logic                  player_mode;
  logic [CFG_DATA_W-1:0] init_bytes;
  logic [BANK_BITS-1:0]  banks [WINDOW_COUNT];

  map_result_t expected_beats [$];

  function automatic void reset_mapper();
    prg_size    = RESET_PRG_SIZE;
    tune_base   = RESET_LOAD_ADDR;
    sound_en    = '0;
    player_mode = 1'b1;
    init_bytes  = '0;
    for (int w = 0; w < WINDOW_COUNT; w++) banks[w] = '0;
  endfunction

  // number of 4 KiB banks the tune spans
  function automatic int unsigned bank_total();
    return (int'(prg_size) + int'(tune_base[OFFS_W-1:0]) + int'(WINDOW_MASK)) >> OFFS_W;
  endfunction

  function automatic logic [BANK_BITS-1:0] set_bank(input int unsigned w,
                                                    input int unsigned d);
    int unsigned n;
    int unsigned b;
    n = bank_total();
    b = (n == 0) ? 0 : d % n;
    banks[w[WIN_W-1:0]] = b[BANK_BITS-1:0];
    return banks[w[WIN_W-1:0]];
  endfunction

  // expected result of one input beat, updates the bank mirror
  function automatic map_result_t map_access(input logic [OP_W-1:0] op,
                                             input logic [ADDR_W-1:0] a,
                                             input logic [BANK_BITS-1:0] d);
    map_result_t r;
    logic blocked;
    int unsigned start;
    int unsigned stop;
    int unsigned last;
    r = '0;
    blocked = 1'b0;
    case (op)
      OP_WRITE: begin
        if (a >= ADDR_LOW_PORT && a <= ADDR_LOW_END) begin
          if (sound_en[EN_N163] && a == ADDR_N163_LO) r.forward_mask[FW_N163_LO] = 1'b1;
          // mmc5 swallows most of $5xxx before bank select sees it
          if (sound_en[EN_MMC5] && a >= ADDR_MMC5) begin
            r.forward_mask[FW_MMC5] = 1'b1;
            blocked = (a <= ADDR_MMC5_END);
          end
          if (!blocked) begin
            if (a >= ADDR_MMC5) begin
              if (a >= ADDR_BANK_SEL) begin
                r.bank_written = 1'b1;
                r.bank_window  = a[WIN_W-1:0];
                r.bank_value   = set_bank(32'(a[WIN_W-1:0]), 32'(d));
              end
            end else if (sound_en[EN_FDS]) begin
              r.forward_mask[FW_FDS] = 1'b1;
            end
          end
        end else if (a[ADDR_W-1]) begin
          if (sound_en[EN_VRC6] &&
              ((a >= ADDR_VRC6_A && a <= ADDR_VRC6_A_E) ||
               (a >= ADDR_VRC6_B && a <= ADDR_VRC6_B_E) ||
               (a >= ADDR_VRC6_C && a <= ADDR_VRC6_C_E)))
            r.forward_mask[FW_VRC6] = 1'b1;
          if (sound_en[EN_VRC7] && (a == ADDR_VRC7_A || a == ADDR_VRC7_D))
            r.forward_mask[FW_VRC7] = 1'b1;
          if (sound_en[EN_N163] && a == ADDR_N163_HI) r.forward_mask[FW_N163_HI] = 1'b1;
          if (sound_en[EN_FME7] && (a == ADDR_FME7_A || a == ADDR_FME7_D))
            r.forward_mask[FW_FME7] = 1'b1;
        end
      end
      OP_READ: begin
        if (a[ADDR_W-1]) r.rom_offset = {banks[a[14:12]], a[OFFS_W-1:0]};
        else r.status = STAT_OUTSIDE;
      end
      OP_INIT: begin
        if (player_mode) begin
          if (!tune_base[ADDR_W-1]) begin
            r.status = STAT_BAD_LOAD;
          end else begin
            start = 32'(tune_base[14:12]);
            if (init_bytes != '0) begin
              for (int unsigned w = start; w < WINDOW_COUNT; w++)
                void'(set_bank(w, 32'(init_bytes[8*w +: 8])));
            end else begin
              // linear fill, clipped at the top window
              stop = bank_total() + start;
              if (stop > WINDOW_COUNT) stop = WINDOW_COUNT;
              for (int unsigned w = start; w < stop; w++) void'(set_bank(w, w - start));
            end
          end
        end else begin
          // plain cartridge: last bank in the top window
          last = 32'(prg_size >> OFFS_W);
          banks[WIN_LAST] = (last == 0) ? '0 : BANK_BITS'(last - 1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count++;
    if (fail_count <= PRINT_LIMIT)
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  initial reset_mapper();

  // watch both channels and the register port
  always @(posedge clk) begin : monitor
    map_result_t seen;
    map_result_t want;
    if (!rst_n) begin
      reset_mapper();
      expected_beats.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen = '{forward_mask: out_ch.forward_mask, bank_written: out_ch.bank_written,
                 bank_window: out_ch.bank_window, bank_value: out_ch.bank_value,
                 rom_offset: out_ch.rom_offset, status: out_ch.status};
        if (expected_beats.size() == 0) begin
          report("result beat with nothing pending", 32'(seen), '0);
        end else begin
          want = expected_beats.pop_front();
          check_field("forward_mask", 32'(seen.forward_mask), 32'(want.forward_mask));
          check_field("bank_written", 32'(seen.bank_written), 32'(want.bank_written));
          check_field("bank_window", 32'(seen.bank_window), 32'(want.bank_window));
          check_field("bank_value", 32'(seen.bank_value), 32'(want.bank_value));
          check_field("rom_offset", 32'(seen.rom_offset), 32'(want.rom_offset));
          check_field("status", 32'(seen.status), 32'(want.status));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_beats.push_back(map_access(in_ch.op, in_ch.cpu_address, in_ch.write_data));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PRG_SIZE:   prg_size    = cfg_wdata[PRG_W-1:0];
          REG_LOAD_ADDR:  tune_base   = cfg_wdata[ADDR_W-1:0];
          REG_SOUND_MASK: sound_en    = cfg_wdata[SOUND_W-1:0];
          REG_NSF_MODE:   player_mode = cfg_wdata[0];
          REG_INIT_WORDS: init_bytes  = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = expected_beats.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import nsfm_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 5;
  localparam int PHASES        = 8;
  localparam int PHASE_BEATS   = 200;
  localparam int SQUEEZE_AT    = 700;
  localparam int SQUEEZE_LEN   = 300;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 80;
  localparam int MAX_CYCLES    = 1_200_000;

  // op code the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [PRG_W-1:0]      prg;
    logic [ADDR_W-1:0]     load;
    logic [SOUND_W-1:0]    sound;
    logic                  mode;
    logic [CFG_DATA_W-1:0] init;
  } setup_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    pending;
  int                    fail_count;
  int                    beats_sent = 0;
  logic                  sender_gaps = 1'b1;

  nsfm_in_if  in_ch ();
  nsfm_out_if out_ch ();

  nsf_bank_switch_mapper u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nsfm_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always #(CLK_HALF) clk = ~clk;

  // hard stop if the block hangs
  initial begin
    repeat (MAX_CYCLES) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // addresses on the edges of the chip decode ranges
  function automatic logic [ADDR_W-1:0] hot_address();
    case ($urandom_range(0, 17))
      0:  return ADDR_LOW_PORT;
      1:  return ADDR_LOW_PORT - 16'd1;
      2:  return ADDR_N163_LO;
      3:  return ADDR_MMC5;
      4:  return ADDR_MMC5 - 16'd1;
      5:  return ADDR_MMC5_END;
      6:  return ADDR_MMC5_END + 16'd1;
      7:  return ADDR_VRC6_A;
      8:  return ADDR_VRC6_A_E;
      9:  return ADDR_VRC6_A_E + 16'd1;
      10: return ADDR_VRC6_B_E;
      11: return ADDR_VRC6_C;
      12: return ADDR_VRC6_C_E;
      13: return ADDR_VRC7_A;
      14: return ADDR_VRC7_D;
      15: return ADDR_N163_HI;
      16: return ADDR_FME7_A;
      default: return ADDR_FME7_D;
    endcase
  endfunction

  // fixed corner settings first, random ones after
  function automatic setup_t phase_setup(input int k);
    setup_t s;
    case (k)
      0: s = '{prg: 21'd1, load: 16'h0000, sound: 6'h00, mode: 1'b1, init: '0};
      1: s = '{prg: 21'h100000, load: 16'hFFFF, sound: 6'h3F, mode: 1'b1, init: '1};
      2: s = '{prg: 21'd0, load: 16'h9000, sound: 6'h15, mode: 1'b0,
               init: 64'h0102_0304_0506_0708};
      3: s = '{prg: 21'h20000, load: 16'h8ABC, sound: 6'h2A, mode: 1'b1, init: '0};
      default: begin
        s.prg   = ($urandom_range(0, 1) == 0) ? PRG_W'($urandom_range(1, 16) * 4096)
                                              : PRG_W'($urandom_range(1, 1048576));
        s.load  = ($urandom_range(0, 4) != 0) ? {1'b1, 15'($urandom)} : ADDR_W'($urandom);
        s.sound = SOUND_W'($urandom);
        s.mode  = ($urandom_range(0, 3) != 0);
        s.init  = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
      end
    endcase
    return s;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_setup(input setup_t s);
    cfg_write(REG_PRG_SIZE, CFG_DATA_W'(s.prg));
    cfg_write(REG_LOAD_ADDR, CFG_DATA_W'(s.load));
    cfg_write(REG_SOUND_MASK, CFG_DATA_W'(s.sound));
    cfg_write(REG_NSF_MODE, CFG_DATA_W'(s.mode));
    cfg_write(REG_INIT_WORDS, s.init);
  endtask

  // offer one beat, valid stays up until the next beat or a gap
  task automatic offer_beat(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic [BANK_BITS-1:0] data);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.cpu_address <= addr;
    in_ch.write_data  <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // typical tune traffic: bank switches and fetches, with some noise
  task automatic random_beat();
    int pick;
    logic [BANK_BITS-1:0] data;
    pick = $urandom_range(0, 99);
    data = BANK_BITS'($urandom);
    if (pick < 8) offer_beat(OP_INIT, ADDR_W'($urandom), data);
    else if (pick < 33) offer_beat(OP_WRITE, ADDR_BANK_SEL + ADDR_W'($urandom_range(0, 7)), data);
    else if (pick < 48) offer_beat(OP_WRITE, hot_address(), data);
    else if (pick < 58) offer_beat(OP_WRITE, ADDR_W'($urandom), data);
    else if (pick < 88) offer_beat(OP_READ, {1'b1, 15'($urandom)}, data);
    else if (pick < 98) offer_beat(OP_READ, ADDR_W'($urandom), data);
    else offer_beat(OP_UNUSED, ADDR_W'($urandom), data);
  endtask

  // stop offering and let every pending result come back
  task automatic wait_idle();
    int guard;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result side back-pressure, including one long hold-off
  initial begin : receiver
    logic level;
    int   span;
    int   r;
    bit   squeezed;
    squeezed = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      r = $urandom_range(0, 99);
      if (!squeezed && beats_sent >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        level = 1'b0;
        span  = SQUEEZE_LEN;
      end else if (r < 20) begin
        level = 1'b1;
        span  = $urandom_range(30, 150);
      end else if (r < 70) begin
        level = 1'b1;
        span  = $urandom_range(1, 4);
      end else if (r < 93) begin
        level = 1'b0;
        span  = $urandom_range(1, 3);
      end else begin
        level = 1'b0;
        span  = $urandom_range(10, 50);
      end
      @(negedge clk);
      out_ch.ready <= level;
      repeat (span - 1) @(negedge clk);
    end
  end

  initial begin : stimulus
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_WRITE;
    in_ch.cpu_address = '0;
    in_ch.write_data  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // a few beats against the reset defaults
    offer_beat(OP_READ, 16'hFFFF, 8'h00);
    offer_beat(OP_WRITE, 16'h5FFB, 8'hAB);
    offer_beat(OP_INIT, 16'h0000, 8'h00);
    wait_idle();

    // directed: 32 KiB tune at $8000, every sound chip enabled
    apply_setup('{prg: 21'h8000, load: 16'h8000, sound: 6'h3F, mode: 1'b1, init: '0});
    offer_beat(OP_INIT, 16'h0000, 8'h00);
    offer_beat(OP_READ, 16'h8000, 8'h00);
    offer_beat(OP_READ, 16'hFFFF, 8'hFF);
    offer_beat(OP_READ, 16'h7FFF, 8'h00);
    offer_beat(OP_READ, 16'h0000, 8'h00);
    offer_beat(OP_WRITE, 16'h5FF8, 8'hFF);
    offer_beat(OP_WRITE, 16'h5FFF, 8'h00);
    offer_beat(OP_READ, 16'hF123, 8'h00);
    offer_beat(OP_WRITE, ADDR_MMC5_END, 8'h55);
    offer_beat(OP_WRITE, ADDR_MMC5, 8'h11);
    offer_beat(OP_WRITE, 16'h5FF6, 8'h22);
    offer_beat(OP_WRITE, ADDR_N163_LO, 8'h33);
    offer_beat(OP_WRITE, ADDR_LOW_PORT, 8'h44);
    offer_beat(OP_WRITE, ADDR_LOW_PORT - 16'd1, 8'h66);
    offer_beat(OP_WRITE, ADDR_VRC6_A, 8'h01);
    offer_beat(OP_WRITE, ADDR_VRC6_A_E, 8'h02);
    offer_beat(OP_WRITE, ADDR_VRC6_B_E, 8'h03);
    offer_beat(OP_WRITE, ADDR_VRC6_C_E, 8'h04);
    offer_beat(OP_WRITE, ADDR_VRC7_A, 8'h05);
    offer_beat(OP_WRITE, ADDR_VRC7_D, 8'h06);
    offer_beat(OP_WRITE, ADDR_N163_HI, 8'h07);
    offer_beat(OP_WRITE, ADDR_FME7_A, 8'h08);
    offer_beat(OP_WRITE, ADDR_FME7_D, 8'h09);
    offer_beat(OP_WRITE, 16'hFFFF, 8'hFF);
    offer_beat(OP_UNUSED, ADDR_BANK_SEL, 8'h77);

    // corner then random phases, each starting like a new song
    for (int k = 0; k < PHASES; k++) begin
      wait_idle();
      apply_setup(phase_setup(k));
      sender_gaps = (k != 1);
      offer_beat(OP_INIT, ADDR_W'($urandom), BANK_BITS'($urandom));
      for (int n = 0; n < PHASE_BEATS; n++) random_beat();
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
